// ===== hdl/dmac_pkg.sv =====
package dmac_pkg;

    // input word: one item of a write-register command
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
        logic        is_first;
        logic        is_last;
    } t_dmac_in;

    // output word: one emitted result
    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic [3:0] status;
        logic [1:0] warning;
        logic       last_of_run;
    } t_dmac_out;

    // queue entry: all results of one item, one or two words
    typedef struct packed {
        logic       two;
        logic       has_byte;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [3:0] status;
        logic [1:0] warning;
    } t_dmac_entry;

    localparam int DMAC_QUEUE_DEPTH = 2;

    // status codes
    localparam logic [3:0] STATUS_OK      = 4'd0;
    localparam logic [3:0] STATUS_RANGE   = 4'd1;
    localparam logic [3:0] STATUS_BASE    = 4'd2;
    localparam logic [3:0] STATUS_MISSING = 4'd3;
    localparam logic [3:0] STATUS_EXTRA   = 4'd4;
    localparam logic [3:0] STATUS_PORT_A  = 4'd5;
    localparam logic [3:0] STATUS_PORT_B  = 4'd6;
    localparam logic [3:0] STATUS_INTR    = 4'd7;
    localparam logic [3:0] STATUS_MODE    = 4'd8;

    // warning codes
    localparam logic [1:0] WARN_NONE   = 2'd0;
    localparam logic [1:0] WARN_HALF   = 2'd1;
    localparam logic [1:0] WARN_UNSUPP = 2'd2;

    // write register numbers
    localparam logic [2:0] FUNC_WR0 = 3'd0;
    localparam logic [2:0] FUNC_WR1 = 3'd1;
    localparam logic [2:0] FUNC_WR2 = 3'd2;
    localparam logic [2:0] FUNC_WR3 = 3'd3;
    localparam logic [2:0] FUNC_WR4 = 3'd4;

    // argument stage codes; 2..5 name the next expected argument
    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_DONE  = 3'd1;
    localparam logic [2:0] STAGE_ARG_A = 3'd2;
    localparam logic [2:0] STAGE_ARG_B = 3'd3;
    localparam logic [2:0] STAGE_ARG_C = 3'd4;
    localparam logic [2:0] STAGE_ARG_D = 3'd5;

    // bit masks of the base and timing bytes
    localparam logic [7:0] MASK_83 = 8'h83;
    localparam logic [7:0] MASK_87 = 8'h87;
    localparam logic [7:0] MASK_18 = 8'h18;
    localparam logic [7:0] MASK_60 = 8'h60;
    localparam logic [7:0] MASK_CC = 8'hCC;
    localparam logic [7:0] MASK_64 = 8'h64;
    localparam logic [7:0] MASK_0C = 8'h0C;
    localparam logic [7:0] MASK_81 = 8'h81;
    localparam logic [7:0] MASK_30 = 8'h30;
    localparam logic [7:0] MASK_03 = 8'h03;
    localparam logic [7:0] MASK_01 = 8'h01;
    localparam logic [7:0] MASK_04 = 8'h04;
    localparam logic [7:0] MASK_08 = 8'h08;
    localparam logic [7:0] MASK_10 = 8'h10;
    localparam logic [7:0] MASK_20 = 8'h20;
    localparam logic [7:0] MASK_40 = 8'h40;
    localparam logic [7:0] MASK_80 = 8'h80;

    function automatic logic stage_needed(input logic [2:0] rnum, input logic [2:0] st,
                                          input logic [7:0] b, input logic [7:0] t);
        logic res;
        res = 1'b0;
        case (rnum)
            FUNC_WR0: res = (st == STAGE_ARG_A && (b & MASK_18) != 8'h00) ||
                            (st == STAGE_ARG_B && (b & MASK_60) != 8'h00);
            FUNC_WR1: res = (st == STAGE_ARG_C && (b & MASK_40) != 8'h00);
            FUNC_WR2: res = (st == STAGE_ARG_C && (b & MASK_40) != 8'h00) ||
                            (st == STAGE_ARG_D && (b & MASK_40) != 8'h00 &&
                             (t & MASK_20) != 8'h00);
            FUNC_WR3: res = (st == STAGE_ARG_A && (b & MASK_08) != 8'h00) ||
                            (st == STAGE_ARG_B && (b & MASK_10) != 8'h00);
            FUNC_WR4: res = (st == STAGE_ARG_A && (b & MASK_04) != 8'h00) ||
                            (st == STAGE_ARG_B && (b & MASK_0C) == MASK_08);
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic stage_is_word(input logic [2:0] rnum, input logic [2:0] st,
                                           input logic [7:0] b);
        return (rnum == FUNC_WR0 && st == STAGE_ARG_A && (b & MASK_18) == MASK_18) ||
               (rnum == FUNC_WR0 && st == STAGE_ARG_B && (b & MASK_60) == MASK_60) ||
               (rnum == FUNC_WR4 && st == STAGE_ARG_A && (b & MASK_0C) == MASK_0C);
    endfunction

    // lowest argument stage above after that the command still needs
    function automatic logic [2:0] next_stage(input logic [2:0] rnum, input logic [2:0] after,
                                              input logic [7:0] b, input logic [7:0] t);
        logic [2:0] res;
        logic [2:0] k;
        res = STAGE_DONE;
        for (int i = 5; i >= 2; i--) begin
            k = 3'(i);
            if (k > after && stage_needed(rnum, k, b, t)) begin
                res = k;
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/dmac_front.sv =====
module dmac_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  dmac_pkg::t_dmac_in   i_in_word,
    input  logic                 i_full,
    output logic                 o_push,
    output dmac_pkg::t_dmac_entry o_entry
);
    import dmac_pkg::*;

    logic [2:0] r_sel, n_sel;
    logic [2:0] r_stage, n_stage;
    logic [7:0] r_base, n_base;
    logic [7:0] r_timing, n_timing;
    logic       r_aborted, n_aborted;

    logic       accept;
    logic [7:0] v_b;
    logic [7:0] v_lo;
    logic [3:0] v_err;
    logic [1:0] v_warn;
    logic [2:0] v_stage;

    assign accept = i_in_valid && !i_full;
    assign v_lo   = i_in_word.value[7:0];

    always_comb begin
        n_sel     = r_sel;
        n_stage   = r_stage;
        n_base    = r_base;
        n_timing  = r_timing;
        n_aborted = r_aborted;
        o_push    = 1'b0;
        o_entry   = '0;
        v_b       = v_lo;
        v_err     = STATUS_OK;
        v_warn    = WARN_NONE;
        v_stage   = r_stage;
        if (accept) begin
            if (i_in_word.is_first) begin
                // base byte: check fixed bits, force the ones that are set
                n_aborted = 1'b0;
                n_sel     = i_in_word.func;
                n_timing  = 8'h00;
                if (i_in_word.value[15:8] != 8'h00) begin
                    v_err = STATUS_RANGE;
                end else begin
                    case (i_in_word.func)
                        FUNC_WR0: begin
                            if ((v_b & MASK_83) != MASK_01) v_err = STATUS_BASE;
                        end
                        FUNC_WR1: begin
                            if (((v_b & MASK_87) | MASK_04) != MASK_04) v_err = STATUS_BASE;
                            v_b = v_b | MASK_04;
                        end
                        FUNC_WR2: begin
                            if ((v_b & MASK_87) != 8'h00) v_err = STATUS_BASE;
                        end
                        FUNC_WR3: begin
                            if (((v_b & MASK_83) | MASK_80) != MASK_80) v_err = STATUS_BASE;
                            v_b = v_b | MASK_80;
                            if ((v_b & MASK_64) != 8'h00) v_warn = WARN_UNSUPP;
                        end
                        FUNC_WR4: begin
                            if (((v_b & MASK_83) | MASK_81) != MASK_81) begin
                                v_err = STATUS_BASE;
                            end else if ((v_b & MASK_10) != 8'h00) begin
                                v_err = STATUS_INTR;
                            end else if ((v_b & MASK_60) == 8'h00 ||
                                         (v_b & MASK_60) == MASK_60) begin
                                v_err = STATUS_MODE;
                            end
                            v_b = v_b | MASK_81;
                        end
                        default: v_err = STATUS_BASE;
                    endcase
                end
                o_push = 1'b1;
                if (v_err != STATUS_OK) begin
                    o_entry.status = v_err;
                    n_stage   = i_in_word.is_last ? STAGE_IDLE : STAGE_DONE;
                    n_aborted = !i_in_word.is_last;
                end else begin
                    n_base  = v_b;
                    v_stage = next_stage(i_in_word.func, STAGE_IDLE, v_b, 8'h00);
                    o_entry.has_byte = 1'b1;
                    o_entry.lo       = v_b;
                    o_entry.warning  = v_warn;
                    o_entry.status   = (i_in_word.is_last && v_stage != STAGE_DONE) ?
                                       STATUS_MISSING : STATUS_OK;
                    n_stage = i_in_word.is_last ? STAGE_IDLE : v_stage;
                end
            end else if (r_stage == STAGE_IDLE || r_aborted) begin
                // no open command, or one already failed
                if (i_in_word.is_last) begin
                    n_stage   = STAGE_IDLE;
                    n_aborted = 1'b0;
                end
            end else if (r_stage == STAGE_DONE) begin
                o_push         = 1'b1;
                o_entry.status = STATUS_EXTRA;
                if (i_in_word.is_last) begin
                    n_stage   = STAGE_IDLE;
                    n_aborted = 1'b0;
                end else begin
                    n_aborted = 1'b1;
                end
            end else if (i_in_word.value[15:8] != 8'h00 &&
                         !stage_is_word(r_sel, r_stage, r_base)) begin
                o_push         = 1'b1;
                o_entry.status = STATUS_RANGE;
                if (i_in_word.is_last) begin
                    n_stage   = STAGE_IDLE;
                    n_aborted = 1'b0;
                end else begin
                    n_aborted = 1'b1;
                end
            end else begin
                o_push           = 1'b1;
                o_entry.has_byte = 1'b1;
                o_entry.lo       = v_lo;
                o_entry.hi       = i_in_word.value[15:8];
                o_entry.two      = stage_is_word(r_sel, r_stage, r_base);
                // timing byte of port a or b
                if (r_stage == STAGE_ARG_C && (r_sel == FUNC_WR1 || r_sel == FUNC_WR2)) begin
                    if (r_sel == FUNC_WR1) begin
                        if ((v_lo & MASK_30) != 8'h00 || (v_lo & MASK_03) == MASK_03)
                            v_err = STATUS_PORT_A;
                    end else begin
                        if ((v_lo & MASK_10) != 8'h00 || (v_lo & MASK_03) == MASK_03)
                            v_err = STATUS_PORT_B;
                    end
                    if (v_err == STATUS_OK && (v_lo & MASK_CC) != 8'h00) v_warn = WARN_HALF;
                end
                o_entry.warning = v_warn;
                if (v_err != STATUS_OK) begin
                    o_entry.status = v_err;
                    if (i_in_word.is_last) begin
                        n_stage   = STAGE_IDLE;
                        n_aborted = 1'b0;
                    end else begin
                        n_aborted = 1'b1;
                    end
                end else begin
                    if (r_stage == STAGE_ARG_C &&
                        (r_sel == FUNC_WR1 || r_sel == FUNC_WR2)) begin
                        n_timing = v_lo;
                        v_stage  = next_stage(r_sel, r_stage, r_base, v_lo);
                    end else begin
                        v_stage  = next_stage(r_sel, r_stage, r_base, r_timing);
                    end
                    o_entry.status = (i_in_word.is_last && v_stage != STAGE_DONE) ?
                                     STATUS_MISSING : STATUS_OK;
                    n_stage = i_in_word.is_last ? STAGE_IDLE : v_stage;
                    if (i_in_word.is_last) n_aborted = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= FUNC_WR0;
            r_stage   <= STAGE_IDLE;
            r_base    <= 8'h00;
            r_timing  <= 8'h00;
            r_aborted <= 1'b0;
        end else begin
            r_sel     <= n_sel;
            r_stage   <= n_stage;
            r_base    <= n_base;
            r_timing  <= n_timing;
            r_aborted <= n_aborted;
        end
    end

endmodule

// ===== hdl/dmac_queue.sv =====
module dmac_queue #(
    parameter int DEPTH = dmac_pkg::DMAC_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dmac_pkg::t_dmac_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output dmac_pkg::t_dmac_entry o_head
);
    import dmac_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_dmac_entry       r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, n_wr;
    logic [PtrW-1:0]   r_rd, n_rd;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_entry;
    end

endmodule

// ===== hdl/dmac_back.sv =====
module dmac_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  dmac_pkg::t_dmac_entry i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dmac_pkg::t_dmac_out   o_out_word
);
    import dmac_pkg::*;

    logic        r_valid;
    logic        r_phase;
    t_dmac_entry r_entry;
    logic        done;
    logic        load;

    // an entry is finished when its final word leaves
    assign done  = r_valid && !i_out_stall && (!r_entry.two || r_phase);
    assign load  = !r_valid || done;
    assign o_pop = load && !i_empty;

    assign o_out_valid = r_valid;

    always_comb begin
        o_out_word = '0;
        if (r_entry.two && !r_phase) begin
            o_out_word.byte_out    = r_entry.lo;
            o_out_word.has_byte    = 1'b1;
            o_out_word.status      = STATUS_OK;
            o_out_word.warning     = WARN_NONE;
            o_out_word.last_of_run = 1'b0;
        end else begin
            o_out_word.byte_out    = r_entry.two ? r_entry.hi : r_entry.lo;
            o_out_word.has_byte    = r_entry.has_byte;
            o_out_word.status      = r_entry.status;
            o_out_word.warning     = r_entry.warning;
            o_out_word.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_phase <= 1'b0;
        end else if (r_valid && !i_out_stall) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_entry <= i_head;
    end

endmodule

// ===== hdl/dma_register_command_checker_core.sv =====
// path: an accepted item's results are registered in the queue, then loaded into the output register
// throughput: one item per cycle while each item gives a single output word and the output
// is not stalled; a word argument gives two output words, the extra output word reaching the
// input as a stall once the two-entry queue between front and back is full
// input stalls only while the queue is full, never on the output stall directly
// reset: synchronous active-low i_rst_n clears command state, queue and output valid
module dma_register_command_checker_core #(
    parameter int QUEUE_DEPTH = dmac_pkg::DMAC_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dmac_pkg::t_dmac_in  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dmac_pkg::t_dmac_out o_out_word
);
    import dmac_pkg::*;

    // front to queue
    logic        front_push;
    t_dmac_entry front_entry;

    // queue to back
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    t_dmac_entry q_head;

    // input stalls only on a full queue, never on the output side directly
    assign o_in_stall = q_full;

    // front: holds the open command, checks each word and builds its results
    dmac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (q_full),
        .o_push     (front_push),
        .o_entry    (front_entry)
    );

    // short queue decoupling front and back
    dmac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: output register, splits word arguments into low then high byte
    dmac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hdl/dmac_checker.sv =====
module dmac_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  dmac_pkg::t_dmac_out o_out_word
);
    import dmac_pkg::*;

    // no byte means a zero byte field
    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.has_byte |-> o_out_word.byte_out == 8'h00)
        else $error("byte_out not zero without has_byte");

    // a word that is not last of its item is the low byte of a word argument
    a_low_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last_of_run |->
            o_out_word.has_byte && o_out_word.status == STATUS_OK &&
            o_out_word.warning == WARN_NONE)
        else $error("low byte of word argument carries status");

    // the high byte follows right after the low byte is taken
    a_high_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_word.last_of_run |=> o_out_valid)
        else $error("high byte of word argument missing");

    // reset empties the queue and the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

endmodule

bind dma_register_command_checker_core dmac_checker u_dmac_checker (.*);

// ===== bench/dmac_emit_check.sv =====
`timescale 1ns / 1ps

module dmac_emit_check
    import dmac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_dmac_in  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_dmac_out i_out_word,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_items,
    output int        o_words,
    output int        o_flagged
);

    // command state as the block should hold it
    logic [2:0] cur_reg;
    logic [2:0] stage;
    logic [7:0] base;
    logic [7:0] timing;
    logic       dropped;

    t_dmac_out expected_words[$];

    // does register rn still take an argument at stage st
    function automatic logic arg_wanted(input logic [2:0] rn, input logic [2:0] st,
                                        input logic [7:0] b, input logic [7:0] t);
        case (rn)
            FUNC_WR0: return (st == STAGE_ARG_A && |b[4:3]) || (st == STAGE_ARG_B && |b[6:5]);
            FUNC_WR1: return st == STAGE_ARG_C && b[6];
            FUNC_WR2: return (st == STAGE_ARG_C && b[6]) ||
                             (st == STAGE_ARG_D && b[6] && t[5]);
            FUNC_WR3: return (st == STAGE_ARG_A && b[3]) || (st == STAGE_ARG_B && b[4]);
            FUNC_WR4: return (st == STAGE_ARG_A && b[2]) ||
                             (st == STAGE_ARG_B && b[3:2] == 2'b10);
            default:  return 1'b0;
        endcase
    endfunction

    // 16-bit arguments, emitted low byte first
    function automatic logic arg_is_pair(input logic [2:0] rn, input logic [2:0] st,
                                         input logic [7:0] b);
        return (rn == FUNC_WR0 && st == STAGE_ARG_A && &b[4:3]) ||
               (rn == FUNC_WR0 && st == STAGE_ARG_B && &b[6:5]) ||
               (rn == FUNC_WR4 && st == STAGE_ARG_A && &b[3:2]);
    endfunction

    function automatic logic [2:0] after_stage(input logic [2:0] st);
        for (int k = int'(st) + 1; k <= 5; k++) begin
            if (k >= 2 && arg_wanted(cur_reg, 3'(k), base, timing)) return 3'(k);
        end
        return STAGE_DONE;
    endfunction

    function automatic t_dmac_out word_of(input logic [7:0] data, input logic has,
                                          input logic [3:0] status, input logic [1:0] warn);
        t_dmac_out w;
        w.byte_out    = has ? data : 8'h00;
        w.has_byte    = has;
        w.status      = status;
        w.warning     = warn;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    function automatic void close_or_drop(input logic is_last);
        if (is_last) begin
            stage   = STAGE_IDLE;
            dropped = 1'b0;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    // single byte-less result that ends the command's useful life
    function automatic void refuse(input logic [3:0] status, input logic is_last);
        t_dmac_out w;
        w = word_of(8'h00, 1'b0, status, WARN_NONE);
        w.last_of_run = 1'b1;
        expected_words.push_back(w);
        close_or_drop(is_last);
    endfunction

    task automatic predict_item(input t_dmac_in w);
        t_dmac_out  res [2];
        int         n;
        logic [3:0] err;
        logic [1:0] warn;
        logic [7:0] b;
        logic [2:0] st;
        err  = STATUS_OK;
        warn = WARN_NONE;
        n    = 0;
        if (w.is_first) begin
            b       = w.value[7:0];
            dropped = 1'b0;
            cur_reg = w.func;
            timing  = 8'h00;
            if (w.value > 16'd255) begin
                err = STATUS_RANGE;
            end else begin
                case (w.func)
                    FUNC_WR0: if (b[7] || b[1:0] != 2'b01) err = STATUS_BASE;
                    FUNC_WR1: begin
                        if (b[7] || b[1:0] != 2'b00) err = STATUS_BASE;
                        b[2] = 1'b1;
                    end
                    FUNC_WR2: if (b[7] || b[2:0] != 3'b000) err = STATUS_BASE;
                    FUNC_WR3: begin
                        if (b[1:0] != 2'b00) err = STATUS_BASE;
                        b[7] = 1'b1;
                        if (b[6] || b[5] || b[2]) warn = WARN_UNSUPP;
                    end
                    FUNC_WR4: begin
                        if (b[1]) err = STATUS_BASE;
                        else if (b[4]) err = STATUS_INTR;
                        else if (b[6] == b[5]) err = STATUS_MODE;
                        b[7] = 1'b1;
                        b[0] = 1'b1;
                    end
                    default: err = STATUS_BASE;
                endcase
            end
            if (err != STATUS_OK) begin
                stage = STAGE_DONE;
                refuse(err, w.is_last);
                return;
            end
            base   = b;
            stage  = after_stage(STAGE_IDLE);
            res[0] = word_of(b, 1'b1, STATUS_OK, warn);
            n      = 1;
        end else begin
            if (stage == STAGE_IDLE || dropped) begin
                if (w.is_last) close_or_drop(1'b1);
                return;
            end
            st = stage;
            if (st == STAGE_DONE) begin
                refuse(STATUS_EXTRA, w.is_last);
                return;
            end
            if (arg_is_pair(cur_reg, st, base)) begin
                res[0] = word_of(w.value[7:0], 1'b1, STATUS_OK, WARN_NONE);
                res[1] = word_of(w.value[15:8], 1'b1, STATUS_OK, WARN_NONE);
                n      = 2;
            end else if (w.value > 16'd255) begin
                refuse(STATUS_RANGE, w.is_last);
                return;
            end else if (st == STAGE_ARG_C && (cur_reg == FUNC_WR1 || cur_reg == FUNC_WR2)) begin
                // timing byte of port a (wr1) or port b (wr2)
                b = w.value[7:0];
                if (cur_reg == FUNC_WR1) begin
                    if (b[5:4] != 2'b00 || b[1:0] == 2'b11) err = STATUS_PORT_A;
                end else if (b[4] || b[1:0] == 2'b11) begin
                    err = STATUS_PORT_B;
                end
                if (err == STATUS_OK && (b & MASK_CC) != 8'h00) warn = WARN_HALF;
                res[0] = word_of(b, 1'b1, err, warn);
                if (err != STATUS_OK) begin
                    res[0].last_of_run = 1'b1;
                    expected_words.push_back(res[0]);
                    close_or_drop(w.is_last);
                    return;
                end
                timing = b;
                n      = 1;
            end else begin
                res[0] = word_of(w.value[7:0], 1'b1, STATUS_OK, WARN_NONE);
                n      = 1;
            end
            stage = after_stage(st);
        end
        if (w.is_last) begin
            if (stage != STAGE_DONE) res[n-1].status = STATUS_MISSING;
            close_or_drop(1'b1);
        end
        res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_words.push_back(res[i]);
    endtask

    always @(posedge i_clk) begin
        t_dmac_out want;
        if (!i_rst_n) begin
            cur_reg      = FUNC_WR0;
            stage        = STAGE_IDLE;
            base         = 8'h00;
            timing       = 8'h00;
            dropped      = 1'b0;
            expected_words.delete();
            o_mismatches = 0;
            o_items      = 0;
            o_words      = 0;
            o_flagged    = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_item(i_in_word);
                o_items++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_words++;
                if (i_out_word.status != STATUS_OK) o_flagged++;
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: unexpected word: byte %02h has %0b status %0d warn %0d last %0b",
                                 $realtime, i_out_word.byte_out, i_out_word.has_byte,
                                 i_out_word.status, i_out_word.warning, i_out_word.last_of_run);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_word !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("%0t: expected byte %02h has %0b status %0d warn %0d last %0b, got byte %02h has %0b status %0d warn %0d last %0b",
                                     $realtime, want.byte_out, want.has_byte, want.status,
                                     want.warning, want.last_of_run, i_out_word.byte_out,
                                     i_out_word.has_byte, i_out_word.status,
                                     i_out_word.warning, i_out_word.last_of_run);
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== bench/dma_register_command_checker_core_test.sv =====
`timescale 1ns / 1ps

module dma_register_command_checker_core_test;
    import dmac_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;

    // ways a random command gets broken
    typedef enum int {
        BREAK_SHORT,
        BREAK_EXTRA,
        BREAK_WIDE,
        BREAK_OPEN,
        BREAK_BASE,
        BREAK_STRAY
    } t_break;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_dmac_in  in_word  = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_dmac_out out_word;

    // idling percentages of the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches;
    int pending;
    int items_seen;
    int words_checked;
    int flagged;
    int words_sent;

    // words of the command being sent
    t_dmac_in cmd[$];

    always #1 clk = ~clk;

    dma_register_command_checker_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    dmac_emit_check emit_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_items     (items_seen),
        .o_words     (words_checked),
        .o_flagged   (flagged)
    );

    // receiver side: random stall, one update per edge, independent of valid
    always @(posedge clk)
        out_stall <= (recv_stall_pct > 0) && (int'($urandom_range(99)) < recv_stall_pct);

    function automatic t_dmac_in cmd_word(input logic [2:0] func, input logic [15:0] value,
                                          input logic is_first, input logic is_last);
        t_dmac_in w;
        w.func     = func;
        w.value    = value;
        w.is_first = is_first;
        w.is_last  = is_last;
        return w;
    endfunction

    // argument word; the func field is ignored there, so it is just random
    function automatic void add_arg(input logic pair);
        cmd.push_back(cmd_word(3'($urandom), pair ? 16'($urandom) : 16'($urandom_range(255)),
                               1'b0, 1'b0));
    endfunction

    // timing byte, mostly legal for the port in question
    function automatic logic [15:0] timing_value(input logic port_b);
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(4) != 0) begin
            if (port_b) v[4] = 1'b0;
            else v[5:4] = 2'b00;
            if (v[1:0] == 2'b11) v[0] = 1'b0;
        end
        return {8'h00, v};
    endfunction

    // present one word, with random idle cycles in front, and hold until taken
    task automatic send_item(input t_dmac_in w);
        while (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        logic [2:0] rn;
        logic [7:0] b;
        logic [15:0] t;
        int pos;
        t_break kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        // argument with no command open
        send_item(cmd_word(FUNC_WR0, 16'h00AA, 1'b0, 1'b1));
        // wr0 with both address and length as words, extreme values
        send_item(cmd_word(FUNC_WR0, 16'h0079, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'hFFFF, 1'b0, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0000, 1'b0, 1'b1));
        // wr4 with a word argument, fixed bits forced
        send_item(cmd_word(FUNC_WR4, 16'h002D, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h1234, 1'b0, 1'b1));
        // wr1 timing byte with half cycle warning
        send_item(cmd_word(FUNC_WR1, 16'h0044, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h000C, 1'b0, 1'b1));
        // wr2 bad port b timing, the rest of the command is dropped
        send_item(cmd_word(FUNC_WR2, 16'h0040, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0023, 1'b0, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0055, 1'b0, 1'b1));
        // wr2 timing byte that asks for the extra argument
        send_item(cmd_word(FUNC_WR2, 16'h0040, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0020, 1'b0, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h00FF, 1'b0, 1'b1));
        // wr3 with unsupported feature bits
        send_item(cmd_word(FUNC_WR3, 16'h0064, 1'b1, 1'b1));
        // wr3 with one argument too many
        send_item(cmd_word(FUNC_WR3, 16'h0000, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0012, 1'b0, 1'b1));
        // register number out of range (7)
        send_item(cmd_word(3'h7, 16'h0000, 1'b1, 1'b1));
        // base value above a byte
        send_item(cmd_word(FUNC_WR0, 16'h0100, 1'b1, 1'b1));
        // wr4 interrupt bit, then illegal mode
        send_item(cmd_word(FUNC_WR4, 16'h0031, 1'b1, 1'b1));
        send_item(cmd_word(FUNC_WR4, 16'h0001, 1'b1, 1'b1));
        // wr0 closed before its argument
        send_item(cmd_word(FUNC_WR0, 16'h0009, 1'b1, 1'b1));
        // wr0 byte argument above 255
        send_item(cmd_word(FUNC_WR0, 16'h0009, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h01FF, 1'b0, 1'b1));
        // new command while one is still open
        send_item(cmd_word(FUNC_WR0, 16'h0019, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR3, 16'h0010, 1'b1, 1'b0));
        send_item(cmd_word(FUNC_WR0, 16'h0077, 1'b0, 1'b1));

        // random part: no idling, sender gaps, receiver stalls, both light
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 17 : 0;
            recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 17 : 0;
            words_sent     = 0;
            while (words_sent < ITEMS_PER_PHASE) begin
                rn = 3'($urandom_range(4));
                b  = 8'($urandom);
                cmd.delete();
                // legal base byte: set the fixed bits each register requires and, for wr4, a legal mode
                case (rn)
                    FUNC_WR0: begin
                        b[7]   = 1'b0;
                        b[1:0] = 2'b01;
                    end
                    FUNC_WR1: begin
                        b[7]   = 1'b0;
                        b[1:0] = 2'b00;
                    end
                    FUNC_WR2: begin
                        b[7]   = 1'b0;
                        b[2:0] = 3'b000;
                    end
                    FUNC_WR3: b[1:0] = 2'b00;
                    default: begin
                        b[4]   = 1'b0;
                        b[1]   = 1'b0;
                        b[6:5] = $urandom_range(1) ? 2'b01 : 2'b10;
                    end
                endcase
                cmd.push_back(cmd_word(rn, {8'h00, b}, 1'b1, 1'b0));
                // arguments that the base byte announces
                case (rn)
                    FUNC_WR0: begin
                        if (b[4:3] != 2'b00) add_arg(&b[4:3]);
                        if (b[6:5] != 2'b00) add_arg(&b[6:5]);
                    end
                    FUNC_WR1: if (b[6]) cmd.push_back(cmd_word(rn, timing_value(1'b0), 1'b0, 1'b0));
                    FUNC_WR2: begin
                        if (b[6]) begin
                            t = timing_value(1'b1);
                            cmd.push_back(cmd_word(rn, t, 1'b0, 1'b0));
                            if (t[5]) add_arg(1'b0);
                        end
                    end
                    FUNC_WR3: begin
                        if (b[3]) add_arg(1'b0);
                        if (b[4]) add_arg(1'b0);
                    end
                    default: begin
                        if (b[2]) add_arg(b[3]);
                        else if (b[3]) add_arg(1'b0);
                    end
                endcase
                cmd[cmd.size()-1].is_last = 1'b1;
                words_sent += cmd.size();
                // about three commands in ten get broken one way or another
                if ($urandom_range(9) < 3) begin
                    kind = t_break'($urandom_range(5));
                    case (kind)
                        BREAK_SHORT: begin
                            if (cmd.size() > 1) begin
                                cmd.delete(cmd.size() - 1);
                                cmd[cmd.size()-1].is_last = 1'b1;
                            end else begin
                                cmd[0].is_last = 1'b0;
                            end
                        end
                        BREAK_EXTRA: begin
                            cmd[cmd.size()-1].is_last = 1'b0;
                            cmd.push_back(cmd_word(3'($urandom), 16'($urandom), 1'b0, 1'b1));
                        end
                        BREAK_WIDE: begin
                            pos = $urandom_range(cmd.size() - 1);
                            cmd[pos].value[15:8] = 8'($urandom_range(1, 255));
                        end
                        BREAK_OPEN: cmd[cmd.size()-1].is_last = 1'b0;
                        BREAK_BASE: begin
                            cmd[0].func  = 3'($urandom);
                            cmd[0].value = ($urandom_range(3) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(255));
                        end
                        default: begin
                            // noise word in front, not counted
                            cmd.push_front(cmd_word(3'($urandom), 16'($urandom), 1'b0,
                                                    1'($urandom)));
                        end
                    endcase
                end
                foreach (cmd[i]) send_item(cmd[i]);
            end
        end

        // drain: wait for every expected word, then keep watching for stragglers
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d command words and %0d result words, %0d of them with an error status,",
                 items_seen, words_checked, flagged);
        $display("under no idling, heavy sender gaps, heavy receiver stalls and light mixed idling");
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // safety net: a hang anywhere ends the run
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
